// ===== src/itp_pkg.sv =====
// Shared types and constants for the infix-to-postfix converter.
// No dependencies; imported by itp_stack, itp_seq and the top level.
package itp_pkg;

   localparam int DEF_STACK_DEPTH   = 32;
   localparam int DEF_PAYLOAD_WIDTH = 32;
   localparam int MAX_RESULTS       = 32;
   localparam int RES_CNT_W         = $clog2(MAX_RESULTS + 1);
   localparam int KIND_W            = 3;
   localparam int PRIO_W            = 3;
   localparam int ERR_W             = 2;
   localparam int PORT_PAY_W        = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_NUM   = 3'd0,
      KIND_VAR   = 3'd1,
      KIND_FUNC  = 3'd2,
      KIND_OPEN  = 3'd3,
      KIND_CLOSE = 3'd4,
      KIND_OPER  = 3'd5,
      KIND_END   = 3'd6
   } tok_kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 2'd0,
      ERR_BRACKET  = 2'd1,
      ERR_OVERFLOW = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_EVAL,
      ST_PUSH,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } stack_ctl_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [ERR_W-1:0]  err;
      logic [KIND_W-1:0] kind;
      logic [PRIO_W-1:0] prio;
   } emit_type;

endpackage

// ===== src/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on itp_pkg, itp_stack and itp_seq.
//
// Usage: tokens enter on the req_ channel (valid/stall), one classified token
// per word. Postfix words leave on the rsp_ channel; rsp_out_last marks the
// final word caused by one token, and an error word carries kind, priority
// and payload of zero.
// Flow: a token is taken while the block is idle and decoded in the next
// cycle. A function or open bracket is pushed there. A number or variable
// is placed in the pending register there and reaches the output register
// from the flush state. Every stack entry examined takes a read state
// (address to the single stack read port) and an evaluate state (registered
// read data); operators, close brackets and end tokens walk the stack this
// way, and an error word leaves through the flush state like a number.
// req_stall is high while a token is in work.
// Reset empties the stack (the entries themselves are not cleared) and the
// output register. A stall on rsp_ holds the output word; the block keeps
// working until it has a further word to hand over, then waits.
module infix_to_postfix_converter
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
   parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_tok_kind,
   input  logic [PRIO_W-1:0]     req_tok_priority,
   input  logic [PORT_PAY_W-1:0] req_tok_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_out_kind,
   output logic [PRIO_W-1:0]     rsp_out_priority,
   output logic [PORT_PAY_W-1:0] rsp_out_payload,
   output logic [ERR_W-1:0]      rsp_out_error,
   output logic                  rsp_out_last
);

   localparam int ENTRY_W = KIND_W + PRIO_W + PAYLOAD_WIDTH;
   localparam int ADDR_W  = $clog2(STACK_DEPTH);

   stack_ctl_type            mem_ctl;
   logic [ADDR_W-1:0]        mem_addr;
   logic [ENTRY_W-1:0]       mem_wdata;
   logic [ENTRY_W-1:0]       mem_rdata;
   emit_type                 emit;
   logic [PAYLOAD_WIDTH-1:0] emit_pay;
   logic                     out_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff;
   logic [PRIO_W-1:0]     rsp_prio_ff;
   logic [PORT_PAY_W-1:0] rsp_pay_ff;
   logic [ERR_W-1:0]      rsp_err_ff;
   logic                  rsp_last_ff;

   itp_stack #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_stack (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   itp_seq #(
      .STACK_DEPTH   (STACK_DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .tok_kind  (req_tok_kind),
      .tok_prio  (req_tok_priority),
      .tok_pay   (PAYLOAD_WIDTH'(req_tok_payload)),
      .out_free  (out_free),
      .emit      (emit),
      .emit_pay  (emit_pay),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // The output register can be loaded when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_kind_ff <= emit.kind;
         rsp_prio_ff <= emit.prio;
         rsp_pay_ff  <= PORT_PAY_W'(emit_pay);
         rsp_err_ff  <= emit.err;
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = rsp_kind_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_out_payload  = rsp_pay_ff;
   assign rsp_out_error    = rsp_err_ff;
   assign rsp_out_last     = rsp_last_ff;

endmodule

// ===== src/itp_stack.sv =====
// Operator stack storage: one write port, one read port with registered data.
// Depends on itp_pkg for the control struct.
module itp_stack
   import itp_pkg::*;
#(
   parameter int DEPTH = DEF_STACK_DEPTH,
   parameter int WIDTH = 6 + DEF_PAYLOAD_WIDTH
) (
   input  logic                     clock,
   input  stack_ctl_type            ctl,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      // The read word holds until the next read so a stalled compare can wait.
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/itp_seq.sv =====
// Sequencer of the converter: latches a token, walks the stack one entry
// per read, compares the top entry and pushes. Depends on itp_pkg.
module itp_seq
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
   parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [KIND_W-1:0]                       tok_kind,
   input  logic [PRIO_W-1:0]                       tok_prio,
   input  logic [PAYLOAD_WIDTH-1:0]                tok_pay,
   input  logic                                    out_free,
   output emit_type                                emit,
   output logic [PAYLOAD_WIDTH-1:0]                emit_pay,
   output stack_ctl_type                           mem_ctl,
   output logic [$clog2(STACK_DEPTH)-1:0]          mem_addr,
   output logic [KIND_W+PRIO_W+PAYLOAD_WIDTH-1:0]  mem_wdata,
   input  logic [KIND_W+PRIO_W+PAYLOAD_WIDTH-1:0]  mem_rdata
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   state_type                state_ff, state_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [PRIO_W-1:0]        prio_ff, prio_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         open_ff, open_in;
   logic [RES_CNT_W-1:0]     n_ff, n_in;
   logic                     fn_phase_ff, fn_phase_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0]        pend_kind_ff, pend_kind_in;
   logic [PRIO_W-1:0]        pend_prio_ff, pend_prio_in;
   logic [PAYLOAD_WIDTH-1:0] pend_pay_ff, pend_pay_in;
   logic [ERR_W-1:0]         pend_err_ff, pend_err_in;

   logic [KIND_W-1:0]        top_kind;
   logic [PRIO_W-1:0]        top_prio;
   logic [PAYLOAD_WIDTH-1:0] top_pay;
   logic [CNT_W-1:0]         count_dec;
   logic                     n_room;
   logic                     stack_full;
   logic                     pend_block;
   logic                     pop_want;
   logic                     req_fire;

   assign top_kind   = mem_rdata[PAYLOAD_WIDTH+PRIO_W +: KIND_W];
   assign top_prio   = mem_rdata[PAYLOAD_WIDTH +: PRIO_W];
   assign top_pay    = mem_rdata[PAYLOAD_WIDTH-1:0];
   assign count_dec  = count_ff - CNT_W'(1);
   assign n_room     = n_ff < RES_CNT_W'(MAX_RESULTS);
   assign stack_full = count_ff == CNT_W'(STACK_DEPTH);
   // The held result may only leave when the output register can take it.
   assign pend_block = pend_valid_ff && !out_free;
   assign req_fire   = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = state_ff != ST_IDLE;

   // Pop decision for the word just read from the top of the stack.
   always_comb begin
      pop_want = 1'b0;
      if (fn_phase_ff) begin
         pop_want = n_room && (top_kind == KIND_FUNC);
      end else begin
         case (kind_ff)
            KIND_CLOSE: pop_want = n_room && (top_kind != KIND_OPEN);
            KIND_OPER:  pop_want = n_room && (top_kind == KIND_OPER) && (top_prio >= prio_ff);
            KIND_END:   pop_want = n_room;
            default:    pop_want = 1'b0;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (kind_ff)
               KIND_NUM, KIND_VAR: state_in = ST_FLUSH;
               KIND_FUNC, KIND_OPEN: state_in = stack_full ? ST_FLUSH : ST_IDLE;
               KIND_CLOSE: state_in = (open_ff == '0) ? ST_FLUSH : ST_READ;
               KIND_OPER: state_in = (count_ff == '0) ? ST_PUSH : ST_READ;
               KIND_END: begin
                  if (open_ff != '0) begin
                     state_in = ST_FLUSH;
                  end else if (count_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_READ;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (pop_want) begin
               if (pend_block) begin
                  state_in = ST_EVAL;
               end else if (fn_phase_ff) begin
                  state_in = ST_FLUSH;
               end else if (count_dec == '0) begin
                  state_in = (kind_ff == KIND_OPER) ? ST_PUSH : ST_FLUSH;
               end else begin
                  state_in = ST_READ;
               end
            end else if (fn_phase_ff) begin
               state_in = ST_FLUSH;
            end else begin
               case (kind_ff)
                  KIND_CLOSE: begin
                     // The open bracket goes; look for a function right below it.
                     if (top_kind == KIND_OPEN && count_dec != '0 && n_room) begin
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_FLUSH;
                     end
                  end
                  KIND_OPER: state_in = ST_PUSH;
                  default:   state_in = ST_FLUSH;
               endcase
            end
         end
         ST_PUSH: state_in = (stack_full && pend_block) ? ST_PUSH : ST_FLUSH;
         ST_FLUSH: state_in = pend_block ? ST_FLUSH : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      kind_in       = kind_ff;
      prio_in       = prio_ff;
      pay_in        = pay_ff;
      count_in      = count_ff;
      open_in       = open_ff;
      n_in          = n_ff;
      fn_phase_in   = fn_phase_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_prio_in  = pend_prio_ff;
      pend_pay_in   = pend_pay_ff;
      pend_err_in   = pend_err_ff;
      mem_ctl       = '0;
      mem_addr      = count_ff[ADDR_W-1:0];
      mem_wdata     = {kind_ff, prio_ff, pay_ff};
      emit.valid    = 1'b0;
      emit.last     = 1'b0;
      emit.err      = pend_err_ff;
      emit.kind     = pend_kind_ff;
      emit.prio     = pend_prio_ff;
      emit_pay      = pend_pay_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in     = tok_kind;
               prio_in     = tok_prio;
               pay_in      = tok_pay;
               n_in        = '0;
               fn_phase_in = 1'b0;
            end
         end
         ST_DECIDE: begin
            case (kind_ff)
               KIND_NUM, KIND_VAR: begin
                  pend_valid_in = 1'b1;
                  pend_kind_in  = kind_ff;
                  pend_prio_in  = prio_ff;
                  pend_pay_in   = pay_ff;
                  pend_err_in   = ERR_NONE;
               end
               KIND_FUNC, KIND_OPEN: begin
                  if (stack_full) begin
                     pend_valid_in = 1'b1;
                     pend_kind_in  = '0;
                     pend_prio_in  = '0;
                     pend_pay_in   = '0;
                     pend_err_in   = ERR_OVERFLOW;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     if (kind_ff == KIND_OPEN) begin
                        open_in = open_ff + CNT_W'(1);
                     end
                  end
               end
               KIND_CLOSE, KIND_END: begin
                  // A close with no open bracket, or an end with one still
                  // stacked, wipes the stack and reports one error word.
                  if ((kind_ff == KIND_CLOSE) == (open_ff == '0)) begin
                     count_in      = '0;
                     open_in       = '0;
                     pend_valid_in = 1'b1;
                     pend_kind_in  = '0;
                     pend_prio_in  = '0;
                     pend_pay_in   = '0;
                     pend_err_in   = ERR_BRACKET;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_READ: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = count_dec[ADDR_W-1:0];
         end
         ST_EVAL: begin
            if (pop_want) begin
               if (!pend_block) begin
                  emit.valid    = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_kind_in  = top_kind;
                  pend_prio_in  = top_prio;
                  pend_pay_in   = top_pay;
                  pend_err_in   = ERR_NONE;
                  count_in      = count_dec;
                  n_in          = n_ff + RES_CNT_W'(1);
               end
            end else if (!fn_phase_ff && kind_ff == KIND_CLOSE && top_kind == KIND_OPEN) begin
               count_in = count_dec;
               open_in  = open_ff - CNT_W'(1);
               if (count_dec != '0 && n_room) begin
                  fn_phase_in = 1'b1;
               end
            end
         end
         ST_PUSH: begin
            if (stack_full) begin
               if (!pend_block) begin
                  emit.valid    = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_kind_in  = '0;
                  pend_prio_in  = '0;
                  pend_pay_in   = '0;
                  pend_err_in   = ERR_OVERFLOW;
               end
            end else begin
               mem_ctl.wr_en = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               emit.valid    = 1'b1;
               emit.last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         open_ff       <= '0;
         n_ff          <= '0;
         fn_phase_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         open_ff       <= open_in;
         n_ff          <= n_in;
         fn_phase_ff   <= fn_phase_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      prio_ff      <= prio_in;
      pay_ff       <= pay_in;
      pend_kind_ff <= pend_kind_in;
      pend_prio_ff <= pend_prio_in;
      pend_pay_ff  <= pend_pay_in;
      pend_err_ff  <= pend_err_in;
   end

   assert property (@(posedge clock) disable iff (reset) open_ff <= count_ff)
      else $error("open bracket count exceeds stack fill");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack fill beyond depth");

   assert property (@(posedge clock) disable iff (reset) emit.valid |-> out_free)
      else $error("word emitted into an occupied output register");

   assert property (@(posedge clock) disable iff (reset)
                    emit.valid && emit.last |=> state_ff == ST_IDLE)
      else $error("last word sent but sequencer not idle");

   assert property (@(posedge clock) disable iff (reset)
                    req_fire |=> state_ff == ST_DECIDE && !pend_valid_ff && n_ff == '0)
      else $error("token accepted with stale result pending");

endmodule

// ===== tb/tb_infix_to_postfix_converter.sv =====
// Self-checking testbench for the shunting-yard infix-to-postfix converter.
// Depends on itp_pkg and infix_to_postfix_converter; a built-in predictor of the
// operator stack works out every postfix word and a checker compares them in order.
module tb_infix_to_postfix_converter;
   import itp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
   localparam int RANDOM_TOKENS = 180;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 100;
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [PRIO_W-1:0]     prio;
      logic [PORT_PAY_W-1:0] payload;
      logic [ERR_W-1:0]      err;
      logic                  last;
   } postfix_word_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [PRIO_W-1:0]     prio;
      logic [PORT_PAY_W-1:0] payload;
   } operator_entry_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_tok_kind;
   logic [PRIO_W-1:0]     req_tok_priority;
   logic [PORT_PAY_W-1:0] req_tok_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [KIND_W-1:0]     rsp_out_kind;
   logic [PRIO_W-1:0]     rsp_out_priority;
   logic [PORT_PAY_W-1:0] rsp_out_payload;
   logic [ERR_W-1:0]      rsp_out_error;
   logic                  rsp_out_last;

   // Predictor state: a copy of the operator stack and the words still owed.
   operator_entry_type op_entries [DEF_STACK_DEPTH];
   int                 op_depth;
   postfix_word_type   fresh_words [$];
   postfix_word_type   expected_words [$];

   int error_count = 0;
   int tokens_sent = 0;
   int cycle_count = 0;
   bit quiet       = 1'b0;
   bit hold_req    = 1'b0;
   bit hold_ack    = 1'b0;

   infix_to_postfix_converter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tok_kind     (req_tok_kind),
      .req_tok_priority (req_tok_priority),
      .req_tok_payload  (req_tok_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_out_error    (rsp_out_error),
      .rsp_out_last     (rsp_out_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic void add_word(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio,
                                    logic [PORT_PAY_W-1:0] payload, logic [ERR_W-1:0] err);
      postfix_word_type w;
      if (fresh_words.size() >= MAX_RESULTS) return;
      w.kind    = kind;
      w.prio    = prio;
      w.payload = payload;
      w.err     = err;
      w.last    = 1'b0;
      fresh_words = {fresh_words, w};
   endfunction

   function automatic void pop_entry();
      op_depth--;
      add_word(op_entries[op_depth].kind, op_entries[op_depth].prio,
               op_entries[op_depth].payload, ERR_NONE);
   endfunction

   function automatic void push_entry(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio,
                                      logic [PORT_PAY_W-1:0] payload);
      if (op_depth >= DEF_STACK_DEPTH) begin
         add_word('0, '0, '0, ERR_OVERFLOW);
      end else begin
         op_entries[op_depth] = '{kind, prio, payload};
         op_depth++;
      end
   endfunction

   function automatic bit open_stacked();
      for (int i = 0; i < op_depth; i++)
         if (op_entries[i].kind == KIND_OPEN) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit top_is(logic [KIND_W-1:0] kind);
      return op_depth > 0 && op_entries[op_depth-1].kind == kind;
   endfunction

   function automatic void predict_token(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio,
                                         logic [PORT_PAY_W-1:0] payload);
      fresh_words.delete();
      case (kind)
         KIND_NUM, KIND_VAR: begin
            add_word(kind, prio, payload, ERR_NONE);
         end
         KIND_FUNC, KIND_OPEN: begin
            push_entry(kind, prio, payload);
         end
         KIND_CLOSE: begin
            if (!open_stacked()) begin
               op_depth = 0;
               add_word('0, '0, '0, ERR_BRACKET);
            end else begin
               while (op_depth > 0 && fresh_words.size() < MAX_RESULTS && !top_is(KIND_OPEN))
                  pop_entry();
               // The open bracket is only dropped when the pops reached it.
               if (top_is(KIND_OPEN)) begin
                  op_depth--;
                  if (fresh_words.size() < MAX_RESULTS && top_is(KIND_FUNC))
                     pop_entry();
               end
            end
         end
         KIND_OPER: begin
            while (fresh_words.size() < MAX_RESULTS && top_is(KIND_OPER) &&
                   op_entries[op_depth-1].prio >= prio)
               pop_entry();
            push_entry(kind, prio, payload);
         end
         KIND_END: begin
            if (open_stacked()) begin
               op_depth = 0;
               add_word('0, '0, '0, ERR_BRACKET);
            end else begin
               while (op_depth > 0 && fresh_words.size() < MAX_RESULTS)
                  pop_entry();
            end
         end
         default: ;
      endcase
      if (fresh_words.size() > 0) fresh_words[fresh_words.size()-1].last = 1'b1;
      expected_words = {expected_words, fresh_words};
   endfunction

   // ---------------- driver and receiver ----------------

   function automatic logic [PRIO_W-1:0] rand_prio();
      return PRIO_W'($urandom_range(7));
   endfunction

   // Called at a rising edge; leaves req_valid high after acceptance so that
   // back-to-back words need no second assignment in the same step.
   task automatic send_token(logic [KIND_W-1:0] kind, logic [PRIO_W-1:0] prio,
                             logic [PORT_PAY_W-1:0] payload);
      if (!quiet) begin
         while ($urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_tok_kind     <= kind;
      req_tok_priority <= prio;
      req_tok_payload  <= payload;
      do @(posedge clock); while (req_stall);
      predict_token(kind, prio, payload);
      if (kind != KIND_UNUSED) tokens_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            rsp_stall <= 1'b1;
            for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 30);
      end
   end

   always @(posedge clock) begin : check_word
      postfix_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0d priority %0d payload %h error %0d",
                   rsp_out_kind, rsp_out_priority, rsp_out_payload, rsp_out_error);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_out_kind !== want.kind) begin
               $error("out_kind: expected %0d, actual %0d", want.kind, rsp_out_kind);
               error_count++;
            end
            if (rsp_out_priority !== want.prio) begin
               $error("out_priority: expected %0d, actual %0d", want.prio, rsp_out_priority);
               error_count++;
            end
            if (rsp_out_payload !== want.payload) begin
               $error("out_payload: expected %h, actual %h", want.payload, rsp_out_payload);
               error_count++;
            end
            if (rsp_out_error !== want.err) begin
               $error("out_error: expected %0d, actual %0d", want.err, rsp_out_error);
               error_count++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %0d, actual %0d", want.last, rsp_out_last);
               error_count++;
            end
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic send_expression();
      int operands;
      int depth;
      operands = $urandom_range(1, 6);
      depth    = 0;
      while (operands > 0) begin
         if (depth < 4 && $urandom_range(99) < 25) begin
            if ($urandom_range(1)) send_token(KIND_FUNC, rand_prio(), $urandom());
            send_token(KIND_OPEN, rand_prio(), $urandom());
            depth++;
            continue;
         end
         send_token($urandom_range(1) ? KIND_NUM : KIND_VAR, rand_prio(), $urandom());
         operands--;
         while (depth > 0 && $urandom_range(99) < 35) begin
            send_token(KIND_CLOSE, rand_prio(), $urandom());
            depth--;
         end
         if (operands > 0) send_token(KIND_OPER, rand_prio(), $urandom());
      end
      while (depth > 0) begin
         send_token(KIND_CLOSE, rand_prio(), $urandom());
         depth--;
      end
      send_token(KIND_END, rand_prio(), $urandom());
   endtask

   // Random kinds, unused kind included; brackets rarely balance here.
   task automatic send_noise();
      repeat ($urandom_range(1, 8))
         send_token(KIND_W'($urandom_range(7)), rand_prio(), $urandom());
      if ($urandom_range(1)) send_token(KIND_END, rand_prio(), $urandom());
   endtask

   task automatic test_directed();
      send_token(KIND_NUM, 3'd0, 32'h0000_0000);
      send_token(KIND_VAR, 3'd7, 32'hFFFF_FFFF);
      send_token(KIND_UNUSED, 3'd7, 32'hAAAA_5555);
      send_token(KIND_END, 3'd2, 32'h1234_5678);      // empty stack: silent
      send_token(KIND_OPER, 3'd3, 32'h0000_0003);     // pops nothing
      send_token(KIND_NUM, 3'd1, 32'h5555_AAAA);
      send_token(KIND_OPER, 3'd3, 32'h0000_0013);     // equal priority pops
      send_token(KIND_OPER, 3'd5, 32'h0000_0005);
      send_token(KIND_NUM, 3'd4, 32'h8000_0000);
      send_token(KIND_OPER, 3'd0, 32'h0000_0000);     // pops both
      send_token(KIND_NUM, 3'd7, 32'h0000_0001);
      send_token(KIND_END, 3'd0, 32'h0);
      send_token(KIND_FUNC, 3'd6, 32'hDEAD_BEEF);
      send_token(KIND_OPEN, 3'd1, 32'hFFFF_FFFF);
      send_token(KIND_NUM, 3'd2, 32'h7FFF_FFFF);
      send_token(KIND_OPER, 3'd7, 32'hFFFF_FFF7);
      send_token(KIND_VAR, 3'd3, 32'h0F0F_0F0F);
      send_token(KIND_CLOSE, 3'd5, 32'h0);            // pops operator, then the function
      send_token(KIND_END, 3'd0, 32'h0);
      send_token(KIND_CLOSE, 3'd7, 32'hFFFF_FFFF);    // unmatched close bracket
      send_token(KIND_OPER, 3'd4, 32'h0000_0044);
      send_token(KIND_OPEN, 3'd0, 32'h0);
      send_token(KIND_NUM, 3'd0, 32'h0000_0099);
      send_token(KIND_END, 3'd7, 32'h0);              // bracket still open
   endtask

   task automatic test_stack_limits();
      // Fill with functions, overflow once, then drain the full stack in one end.
      for (int i = 0; i < DEF_STACK_DEPTH; i++)
         send_token(KIND_FUNC, i[PRIO_W-1:0], $urandom());
      send_token(KIND_FUNC, 3'd1, $urandom());
      send_token(KIND_END, 3'd0, $urandom());
      // Operators on top of a full stack: some pops, then the push fails or fits.
      for (int i = 0; i < DEF_STACK_DEPTH - 2; i++)
         send_token(KIND_OPEN, 3'd0, $urandom());
      send_token(KIND_OPER, 3'd2, $urandom());
      send_token(KIND_OPER, 3'd6, $urandom());
      send_token(KIND_OPER, 3'd7, $urandom());
      send_token(KIND_OPEN, 3'd0, $urandom());
      send_token(KIND_OPER, 3'd1, $urandom());
      send_token(KIND_END, 3'd0, $urandom());
   endtask

   task automatic test_random_expressions();
      int start;
      start = tokens_sent;
      while (tokens_sent - start < RANDOM_TOKENS) begin
         quiet = (tokens_sent - start >= 60) && (tokens_sent - start < 120);
         if ($urandom_range(99) < 15) send_noise();
         else send_expression();
      end
      quiet = 1'b0;
   endtask

   task automatic test_flow_control();
      // Long receiver hold-off while words keep coming, so the block backs up.
      hold_req = !hold_req;
      repeat (6) begin
         for (int i = 0; i < 5; i++) begin
            send_token(KIND_NUM, rand_prio(), $urandom());
            send_token(KIND_OPER, rand_prio(), $urandom());
         end
         send_token(KIND_VAR, rand_prio(), $urandom());
         send_token(KIND_END, rand_prio(), $urandom());
      end
      // Sender pauses until every word is out, then resumes.
      wait_for_drain();
      repeat (4) send_expression();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_tok_kind     = KIND_NUM;
      req_tok_priority = '0;
      req_tok_payload  = '0;
      op_depth         = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_for_drain();
      test_stack_limits();
      wait_for_drain();
      test_random_expressions();
      wait_for_drain();
      test_flow_control();
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
